/* hw/rtl/crtc_pkg.sv */
// shared types, constants and helpers for the line timing controller
package crtc_pkg;

  localparam int unsigned VisibleLines = 272;
  localparam int unsigned NumRegs      = 16;
  localparam int unsigned RegIdxW      = 4;

  localparam logic [8:0] FirstDrawLine = 9'd32;
  localparam logic [8:0] LastDrawLine  = 9'(32 + VisibleLines);
  localparam logic [8:0] FrameLastLine = 9'd312;
  localparam logic [7:0] VsyncWidth    = 8'd16;
  localparam logic [7:0] IrqPeriod     = 8'd52;
  localparam logic [1:0] ResyncLines   = 2'd2;
  localparam logic [7:0] HsyncCenter   = 8'd50;
  localparam logic [9:0] EdgeLimit     = 10'd96;

  localparam logic [RegIdxW-1:0] RegHorizDisplayed = 4'd1;
  localparam logic [RegIdxW-1:0] RegHsyncPos       = 4'd2;
  localparam logic [RegIdxW-1:0] RegVertTotal      = 4'd4;
  localparam logic [RegIdxW-1:0] RegVertDisplayed  = 4'd6;
  localparam logic [RegIdxW-1:0] RegVsyncPos       = 4'd7;
  localparam logic [RegIdxW-1:0] RegMaxRaster      = 4'd9;
  localparam logic [RegIdxW-1:0] RegStartHigh      = 4'd12;
  localparam logic [RegIdxW-1:0] RegStartLow       = 4'd13;

  typedef enum logic [1:0] {
    KIND_SELECT = 2'd0,
    KIND_WRITE  = 2'd1,
    KIND_READ   = 2'd2,
    KIND_TICK   = 2'd3
  } kind_t;

  typedef struct packed {
    logic [6:0]  right_edge;
    logic [6:0]  left_edge;
    logic [15:0] draw_raster_bank;
    logic        draw_enable;
    logic [16:0] draw_address;
    logic [8:0]  draw_row;
    logic        draw_valid;
    logic        irq_pulse;
    logic        vsync_active;
    logic [8:0]  line_number;
    logic [7:0]  read_data;
  } result_t;

  localparam int unsigned ResultW = $bits(result_t);
  localparam int unsigned OutDataW = ((ResultW + 7) / 8) * 8;

  function automatic logic [7:0] write_mask(input logic [4:0] idx);
    logic [7:0] m;
    case (idx) inside
      5'd4, 5'd6, 5'd7, 5'd10: m = 8'h7F;
      5'd8:                    m = 8'hF3;
      5'd5, 5'd9, 5'd11:       m = 8'h1F;
      5'd12, 5'd14:            m = 8'h3F;
      default:                 m = 8'hFF;
    endcase
    return m;
  endfunction

endpackage

/* hw/rtl/crtc_core.sv */
// controller state and the per-transaction next-state and result logic
module crtc_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               fire,
  input  logic [1:0]         kind,
  input  logic [7:0]         data,
  output crtc_pkg::result_t  result
);

  logic [7:0] regs [crtc_pkg::NumRegs];
  logic [4:0] sel;
  logic [7:0] vsync_left;
  logic [6:0] char_row;
  logic [4:0] raster;
  logic [8:0] scan_line;
  logic [15:0] row_addr;
  logic [1:0] resync;
  logic [7:0] irq_count;
  logic       vsync_flag;
  logic [6:0] edge_start;
  logic [6:0] edge_end;

  logic [4:0]  sel_next;
  logic [7:0]  vsync_left_next;
  logic [6:0]  char_row_next;
  logic [4:0]  raster_next;
  logic [8:0]  scan_line_next;
  logic [15:0] row_addr_next;
  logic [1:0]  resync_next;
  logic [7:0]  irq_count_next;
  logic        vsync_flag_next;
  logic [6:0]  edge_start_next;
  logic [6:0]  edge_end_next;
  logic        wr_en;
  logic [7:0]  wr_val;
  logic [7:0]  hsp;
  logic [7:0]  hdisp;
  logic [9:0]  end_sum;
  logic [8:0]  vt_plus;
  logic [8:0]  sl_inc;
  logic [7:0]  cnt_inc;
  logic [1:0]  rs_dec;
  logic [7:0]  rd;
  logic        irq;
  logic        dv;
  logic [8:0]  drow;
  logic        den;
  logic [16:0] daddr;
  logic [15:0] dbank;

  always_comb begin
    sel_next        = sel;
    vsync_left_next = vsync_left;
    char_row_next   = char_row;
    raster_next     = raster;
    scan_line_next  = scan_line;
    row_addr_next   = row_addr;
    resync_next     = resync;
    irq_count_next  = irq_count;
    vsync_flag_next = vsync_flag;
    edge_start_next = edge_start;
    edge_end_next   = edge_end;
    wr_en  = 1'b0;
    wr_val = data & crtc_pkg::write_mask(sel);
    rd     = 8'd0;
    irq    = 1'b0;
    dv     = 1'b0;
    drow   = 9'd0;
    den    = 1'b0;
    daddr  = 17'd0;
    dbank  = 16'd0;
    hsp    = regs[crtc_pkg::RegHsyncPos];
    hdisp  = regs[crtc_pkg::RegHorizDisplayed];
    end_sum = 10'd0;
    vt_plus = {1'b0, regs[crtc_pkg::RegVertTotal]} + 9'd1;
    sl_inc  = scan_line + 9'd1;
    cnt_inc = irq_count + 8'd1;
    rs_dec  = 2'd0;

    case (crtc_pkg::kind_t'(kind))
      crtc_pkg::KIND_SELECT: begin
        sel_next = data[4:0];
      end
      crtc_pkg::KIND_WRITE: begin
        wr_en = ~sel[4];
        // edges use the register values after this write
        if (wr_en && sel[3:0] == crtc_pkg::RegHsyncPos) begin
          hsp = wr_val;
        end
        if (wr_en && sel[3:0] == crtc_pkg::RegHorizDisplayed) begin
          hdisp = wr_val;
        end
        if (hsp >= crtc_pkg::HsyncCenter) begin
          edge_start_next = 7'd0;
        end else begin
          edge_start_next = 7'((crtc_pkg::HsyncCenter - hsp) << 1);
        end
        end_sum = {3'd0, edge_start_next} + {1'b0, hdisp, 1'b0};
        if (end_sum > crtc_pkg::EdgeLimit) begin
          edge_end_next = 7'(crtc_pkg::EdgeLimit);
        end else begin
          edge_end_next = end_sum[6:0];
        end
      end
      crtc_pkg::KIND_READ: begin
        if (sel >= 5'd12 && sel <= 5'd15) begin
          rd = regs[sel[3:0]];
        end else if (sel == 5'd16 || sel == 5'd17) begin
          rd = 8'hFF;
        end
      end
      default: begin
        vsync_left_next = vsync_left - 8'd1;
        if (vsync_left_next == 8'd0) begin
          vsync_flag_next = 1'b0;
        end
        scan_line_next = sl_inc;
        if ({3'd0, raster} == regs[crtc_pkg::RegMaxRaster]) begin
          raster_next   = 5'd0;
          char_row_next = char_row + 7'd1;
          row_addr_next = row_addr + {8'd0, regs[crtc_pkg::RegHorizDisplayed]};
        end else begin
          raster_next = raster + 5'd1;
        end
        if ({2'd0, char_row_next} == vt_plus) begin
          raster_next   = 5'd0;
          char_row_next = 7'd0;
          row_addr_next = {regs[crtc_pkg::RegStartHigh], regs[crtc_pkg::RegStartLow]};
        end
        if ({1'b0, char_row_next} == regs[crtc_pkg::RegVsyncPos] && raster_next == 5'd0) begin
          scan_line_next  = 9'd0;
          vsync_left_next = crtc_pkg::VsyncWidth;
          resync_next     = crtc_pkg::ResyncLines;
          vsync_flag_next = 1'b1;
        end else if (sl_inc >= crtc_pkg::FirstDrawLine && sl_inc < crtc_pkg::LastDrawLine) begin
          dv    = 1'b1;
          drow  = sl_inc - crtc_pkg::FirstDrawLine;
          den   = ({1'b0, char_row_next} < regs[crtc_pkg::RegVertDisplayed]);
          daddr = den ? {row_addr_next, 1'b0} : 17'd0;
          dbank = {raster_next, 11'd0} | {row_addr_next[13:12], 14'd0};
        end else if (sl_inc > crtc_pkg::FrameLastLine) begin
          scan_line_next = 9'd0;
        end

        irq_count_next = cnt_inc;
        if (resync_next == 2'd0) begin
          if (cnt_inc == crtc_pkg::IrqPeriod) begin
            irq_count_next = 8'd0;
            irq            = 1'b1;
          end
        end else begin
          rs_dec      = resync_next - 2'd1;
          resync_next = rs_dec;
          if (rs_dec == 2'd0) begin
            irq            = cnt_inc[5];
            irq_count_next = 8'd0;
          end
        end
      end
    endcase

    result.read_data        = rd;
    result.line_number      = (kind == crtc_pkg::KIND_TICK) ? scan_line_next : 9'd0;
    result.vsync_active     = vsync_flag_next;
    result.irq_pulse        = irq;
    result.draw_valid       = dv;
    result.draw_row         = drow;
    result.draw_address     = daddr;
    result.draw_enable      = den;
    result.draw_raster_bank = dbank;
    result.left_edge        = edge_start_next;
    result.right_edge       = edge_end_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < crtc_pkg::NumRegs; i++) begin
        regs[i] <= (i == 0) ? 8'h00 : 8'hFF;
      end
      sel        <= 5'd0;
      vsync_left <= crtc_pkg::VsyncWidth;
      char_row   <= 7'd0;
      raster     <= 5'd0;
      scan_line  <= 9'd0;
      row_addr   <= 16'd0;
      resync     <= 2'd0;
      irq_count  <= 8'd0;
      vsync_flag <= 1'b0;
      edge_start <= 7'd0;
      edge_end   <= 7'd0;
    end else if (fire) begin
      if (kind == crtc_pkg::KIND_WRITE && wr_en) begin
        regs[sel[3:0]] <= wr_val;
      end
      sel        <= sel_next;
      vsync_left <= vsync_left_next;
      char_row   <= char_row_next;
      raster     <= raster_next;
      scan_line  <= scan_line_next;
      row_addr   <= row_addr_next;
      resync     <= resync_next;
      irq_count  <= irq_count_next;
      vsync_flag <= vsync_flag_next;
      edge_start <= edge_start_next;
      edge_end   <= edge_end_next;
    end
  end

endmodule

/* hw/rtl/crtc_line_timing_irq.sv */
// top level: input register, controller core and result register
// Each transaction is a register select, write or read, or one scan line tick, and
// produces exactly one result transaction. The block takes one transaction per
// clock unless the output side stalls: it is held in an input register while the
// core updates its state and forms the result, which lands in the output register
// and is offered from there until the output side takes it. Both
// registers advance together whenever the output register is empty or being taken,
// so input and output can stream at one transaction per cycle. Reset is synchronous
// and puts the timing registers at 0xFF, register 0 at 0, and all counters at their
// start values.
module crtc_line_timing_irq (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [7:0]                      s_tdata,  // data[7:0]
  input  logic [1:0]                      s_tuser,  // kind[1:0]
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // read_data, line_number, vsync_active, irq_pulse, draw_valid, draw_row,
  // draw_address, draw_enable, draw_raster_bank, left_edge, right_edge, zero pad
  output logic [crtc_pkg::OutDataW-1:0]   m_tdata
);

  logic              in_valid;
  logic [1:0]        in_kind;
  logic [7:0]        in_data;
  logic              advance;
  logic              fire;
  crtc_pkg::result_t res;
  crtc_pkg::result_t out_res;

  assign advance  = ~m_tvalid | m_tready;
  assign s_tready = ~in_valid | advance;
  assign fire     = in_valid & advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
      if (advance) begin
        m_tvalid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_kind <= s_tuser;
      in_data <= s_tdata;
    end
    if (fire) begin
      out_res <= res;
    end
  end

  crtc_core u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .kind   (in_kind),
    .data   (in_data),
    .result (res)
  );

  assign m_tdata = {{(crtc_pkg::OutDataW - crtc_pkg::ResultW){1'b0}}, out_res};

endmodule

/* dv/crtc_checker.sv */
// checker: predicts each result of the line timing controller and compares it on the output
module crtc_checker
  import crtc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  input  logic                s_tready,
  input  logic [7:0]          s_tdata,  // data[7:0]
  input  logic [1:0]          s_tuser,  // kind[1:0]
  input  logic                m_tvalid,
  input  logic                m_tready,
  // read_data, line_number, vsync_active, irq_pulse, draw_valid, draw_row,
  // draw_address, draw_enable, draw_raster_bank, left_edge, right_edge, zero pad
  input  logic [OutDataW-1:0] m_tdata,
  output int unsigned         pending,
  output int unsigned         mismatches,
  output int unsigned         tick_count,
  output int unsigned         draw_count,
  output int unsigned         irq_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [4:0] RegVertAdjust  = 5'd5;
  localparam logic [4:0] RegSkew        = 5'd8;
  localparam logic [4:0] RegCursorStart = 5'd10;
  localparam logic [4:0] RegCursorEnd   = 5'd11;
  localparam logic [4:0] RegCursorHigh  = 5'd14;
  localparam logic [4:0] RegCursorLow   = 5'd15;
  localparam logic [4:0] RegPenHigh     = 5'd16;
  localparam logic [4:0] RegPenLow      = 5'd17;

  logic [7:0]  regs [NumRegs];
  logic [4:0]  sel_idx;
  logic [7:0]  vsync_left;
  logic [6:0]  row_ctr;
  logic [4:0]  raster_ctr;
  logic [8:0]  line_ctr;
  logic [15:0] row_addr;
  logic [1:0]  resync_left;
  logic [7:0]  irq_lines;
  logic        vsync_on;
  logic [6:0]  edge_lo;
  logic [6:0]  edge_hi;
  result_t     expected_q[$];

  function automatic logic [7:0] keep_bits(logic [4:0] idx);
    case (idx)
      RegVertTotal, RegVertDisplayed, RegVsyncPos, RegCursorStart: return 8'h7F;
      RegSkew:                                                     return 8'hF3;
      RegVertAdjust, RegMaxRaster, RegCursorEnd:                   return 8'h1F;
      RegStartHigh, RegCursorHigh:                                 return 8'h3F;
      default:                                                     return 8'hFF;
    endcase
  endfunction

  function automatic void recompute_edges();
    int lo;
    int hi;
    lo = (regs[RegHsyncPos] >= HsyncCenter) ? 0 :
         2 * (int'(HsyncCenter) - int'(regs[RegHsyncPos]));
    hi = lo + 2 * int'(regs[RegHorizDisplayed]);
    if (hi > int'(EdgeLimit)) hi = int'(EdgeLimit);
    edge_lo = 7'(lo);
    edge_hi = 7'(hi);
  endfunction

  function automatic result_t predict_item(kind_t kind, logic [7:0] data);
    result_t r;
    r = '0;
    case (kind)
      KIND_SELECT: sel_idx = data[4:0];
      KIND_WRITE: begin
        if (sel_idx < NumRegs) regs[sel_idx[3:0]] = data & keep_bits(sel_idx);
        recompute_edges();
      end
      KIND_READ: begin
        if (sel_idx >= RegStartHigh && sel_idx <= RegCursorLow) begin
          r.read_data = regs[sel_idx[3:0]];
        end else if (sel_idx == RegPenHigh || sel_idx == RegPenLow) begin
          r.read_data = 8'hFF;
        end
      end
      default: begin
        vsync_left = vsync_left - 8'd1;
        if (vsync_left == 8'd0) vsync_on = 1'b0;
        line_ctr = line_ctr + 9'd1;
        if ({3'b0, raster_ctr} == regs[RegMaxRaster]) begin
          raster_ctr = '0;
          row_ctr = row_ctr + 7'd1;
          row_addr = row_addr + 16'(regs[RegHorizDisplayed]);
        end else begin
          raster_ctr = raster_ctr + 5'd1;
        end
        // vertical total compared one bit wider, so 127 never reloads
        if ({2'b0, row_ctr} == {1'b0, regs[RegVertTotal]} + 9'd1) begin
          raster_ctr = '0;
          row_ctr = '0;
          row_addr = {regs[RegStartHigh], regs[RegStartLow]};
        end
        if ({1'b0, row_ctr} == regs[RegVsyncPos] && raster_ctr == 5'd0) begin
          line_ctr = '0;
          vsync_left = VsyncWidth;
          resync_left = ResyncLines;
          vsync_on = 1'b1;
        end else if (line_ctr >= FirstDrawLine && line_ctr < LastDrawLine) begin
          r.draw_valid = 1'b1;
          r.draw_row = line_ctr - FirstDrawLine;
          r.draw_enable = {1'b0, row_ctr} < regs[RegVertDisplayed];
          r.draw_address = r.draw_enable ? {row_addr, 1'b0} : '0;
          r.draw_raster_bank = {raster_ctr, 11'b0} | {row_addr[13:12], 14'b0};
        end else if (line_ctr > FrameLastLine) begin
          line_ctr = '0;
        end
        irq_lines = irq_lines + 8'd1;
        if (resync_left == 2'd0) begin
          if (irq_lines == IrqPeriod) begin
            irq_lines = '0;
            r.irq_pulse = 1'b1;
          end
        end else begin
          resync_left = resync_left - 2'd1;
          if (resync_left == 2'd0) begin
            r.irq_pulse = irq_lines[5];
            irq_lines = '0;
          end
        end
        r.line_number = line_ctr;
      end
    endcase
    r.vsync_active = vsync_on;
    r.left_edge = edge_lo;
    r.right_edge = edge_hi;
    return r;
  endfunction

  function automatic string field_diffs(result_t e, result_t a);
    string s;
    s = "";
    if (e.read_data !== a.read_data)
      s = {s, $sformatf(" read_data %0h/%0h", e.read_data, a.read_data)};
    if (e.line_number !== a.line_number)
      s = {s, $sformatf(" line_number %0d/%0d", e.line_number, a.line_number)};
    if (e.vsync_active !== a.vsync_active)
      s = {s, $sformatf(" vsync_active %0b/%0b", e.vsync_active, a.vsync_active)};
    if (e.irq_pulse !== a.irq_pulse)
      s = {s, $sformatf(" irq_pulse %0b/%0b", e.irq_pulse, a.irq_pulse)};
    if (e.draw_valid !== a.draw_valid)
      s = {s, $sformatf(" draw_valid %0b/%0b", e.draw_valid, a.draw_valid)};
    if (e.draw_row !== a.draw_row)
      s = {s, $sformatf(" draw_row %0d/%0d", e.draw_row, a.draw_row)};
    if (e.draw_address !== a.draw_address)
      s = {s, $sformatf(" draw_address %0h/%0h", e.draw_address, a.draw_address)};
    if (e.draw_enable !== a.draw_enable)
      s = {s, $sformatf(" draw_enable %0b/%0b", e.draw_enable, a.draw_enable)};
    if (e.draw_raster_bank !== a.draw_raster_bank)
      s = {s, $sformatf(" draw_raster_bank %0h/%0h", e.draw_raster_bank, a.draw_raster_bank)};
    if (e.left_edge !== a.left_edge)
      s = {s, $sformatf(" left_edge %0d/%0d", e.left_edge, a.left_edge)};
    if (e.right_edge !== a.right_edge)
      s = {s, $sformatf(" right_edge %0d/%0d", e.right_edge, a.right_edge)};
    return s;
  endfunction

  always @(posedge clk) begin
    result_t got;
    result_t want;
    string diffs;
    if (rst) begin
      for (int i = 0; i < NumRegs; i++) regs[i] = (i == 0) ? 8'h00 : 8'hFF;
      sel_idx = '0;
      vsync_left = VsyncWidth;
      row_ctr = '0;
      raster_ctr = '0;
      line_ctr = '0;
      row_addr = '0;
      resync_left = '0;
      irq_lines = '0;
      vsync_on = 1'b0;
      edge_lo = '0;
      edge_hi = '0;
      expected_q.delete();
      mismatches = 0;
      tick_count = 0;
      draw_count = 0;
      irq_count = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = result_t'(m_tdata[ResultW-1:0]);
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result transaction at %0t: %h", $time, got);
        end else begin
          want = expected_q.pop_front();
          diffs = field_diffs(want, got);
          if (diffs != "") begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch at %0t (expected/actual):%s", $time, diffs);
          end
        end
      end
      if (s_tvalid && s_tready) begin
        want = predict_item(kind_t'(s_tuser), s_tdata);
        expected_q.push_back(want);
        if (kind_t'(s_tuser) == KIND_TICK) tick_count++;
        if (want.draw_valid) draw_count++;
        if (want.irq_pulse) irq_count++;
      end
    end
    pending = expected_q.size();
  end

endmodule

/* dv/tb_top.sv */
// testbench top: drives bus and line tick transactions into the controller and gives the verdict
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import crtc_pkg::*;

  localparam int unsigned ItemTarget = 1050;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned LongHold   = 150;
  localparam int unsigned TailCycles = 10;

  logic                clk      = 1'b0;
  logic                rst      = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [7:0]          s_tdata  = '0;
  logic [1:0]          s_tuser  = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OutDataW-1:0] m_tdata;

  int unsigned pending;
  int unsigned mismatches;
  int unsigned tick_count;
  int unsigned draw_count;
  int unsigned irq_count;
  int unsigned sent;
  int unsigned holds;
  int unsigned cycles;
  int unsigned sink_gap;
  bit          src_calm;
  bit          sink_calm;
  bit          hold_req;

  crtc_line_timing_irq dut (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser, .m_tvalid, .m_tready, .m_tdata
  );

  crtc_checker chk (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser, .m_tvalid, .m_tready, .m_tdata,
    .pending, .mismatches, .tick_count, .draw_count, .irq_count
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int unsigned gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
  endfunction

  // output side: random stalls, calm stretches, and long hold-offs on request
  always @(negedge clk) begin
    if (rst) begin
      m_tready = 1'b0;
      sink_gap = 0;
    end else if (sink_gap != 0) begin
      sink_gap--;
    end else if (hold_req) begin
      m_tready = 1'b0;
      sink_gap = LongHold - 1;
      hold_req = 1'b0;
      holds++;
    end else begin
      if ($urandom_range(0, 99) == 0) sink_calm = !sink_calm;
      if (!sink_calm && $urandom_range(0, 4) == 0) begin
        m_tready = 1'b0;
        sink_gap = gap_len() - 1;
      end else begin
        m_tready = 1'b1;
      end
    end
  end

  task automatic push_item(kind_t k, logic [7:0] d);
    int unsigned g;
    g = (src_calm || $urandom_range(0, 3) != 0) ? 0 : gap_len();
    @(negedge clk);
    if (g != 0) begin
      s_tvalid = 1'b0;
      repeat (g) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser = k;
    s_tdata = d;
    do @(posedge clk); while (!s_tready);
    sent++;
  endtask

  task automatic set_reg(logic [RegIdxW-1:0] idx, logic [7:0] val);
    push_item(KIND_SELECT, 8'(idx));
    push_item(KIND_WRITE, val);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    while (cycles < CycleLimit) @(posedge clk) cycles++;
    $display("FAIL crtc_line_timing_irq");
    $finish;
  end

  initial begin
    int unsigned phase;
    int unsigned runlen;
    int unsigned vt;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // register file edges, light pen reads, dropped writes, index masking
    push_item(KIND_READ, 8'h00);
    push_item(KIND_SELECT, 8'd16);
    push_item(KIND_READ, 8'hFF);
    push_item(KIND_SELECT, 8'hF1);
    push_item(KIND_READ, 8'h00);
    push_item(KIND_SELECT, 8'd12);
    push_item(KIND_READ, 8'h5A);
    push_item(KIND_SELECT, 8'd31);
    push_item(KIND_WRITE, 8'hAA);
    push_item(KIND_READ, 8'hFF);
    set_reg(RegHsyncPos, 8'h00);
    set_reg(RegHorizDisplayed, 8'h00);
    set_reg(RegHsyncPos, 8'd49);
    set_reg(RegHorizDisplayed, 8'h01);
    set_reg(RegStartLow, 8'hFF);
    push_item(KIND_READ, 8'h00);
    push_item(KIND_SELECT, 8'hEE);
    push_item(KIND_WRITE, 8'hFF);
    push_item(KIND_READ, 8'hFF);
    push_item(KIND_TICK, 8'h00);
    push_item(KIND_TICK, 8'hFF);

    phase = 0;
    while (sent < ItemTarget) begin
      wait_drained();
      src_calm = (phase % 3 == 1) || ($urandom_range(0, 3) == 0);
      set_reg(RegHorizDisplayed, 8'($urandom_range(0, 255)));
      set_reg(RegHsyncPos, 8'($urandom_range(0, 63)));
      set_reg(RegStartHigh, 8'($urandom));
      set_reg(RegStartLow, 8'($urandom));
      case (phase % 5)
        0: begin
          vt = $urandom_range(0, 12);
          set_reg(RegMaxRaster, 8'($urandom_range(0, 3)));
          set_reg(RegVertTotal, 8'(vt));
          set_reg(RegVsyncPos, 8'($urandom_range(0, vt)));
          set_reg(RegVertDisplayed, 8'($urandom_range(0, vt + 1)));
          runlen = 70;
        end
        1: begin
          vt = $urandom_range(10, 38);
          set_reg(RegMaxRaster, 8'($urandom_range(4, 15)));
          set_reg(RegVertTotal, 8'(vt));
          set_reg(RegVsyncPos, 8'($urandom_range(0, vt)));
          set_reg(RegVertDisplayed, 8'($urandom_range(0, vt + 1)));
          runlen = 130;
        end
        2: begin
          // vsync position out of reach: frame ends by the line counter alone
          vt = $urandom_range(0, 20);
          set_reg(RegMaxRaster, 8'($urandom_range(0, 31)));
          set_reg(RegVertTotal, 8'(vt));
          set_reg(RegVsyncPos, 8'h7F);
          set_reg(RegVertDisplayed, 8'($urandom_range(0, vt + 1)));
          runlen = 330;
        end
        3: begin
          // no reload, one row per line, so the row address wraps
          set_reg(RegVertTotal, 8'hFF);
          set_reg(RegMaxRaster, 8'h00);
          set_reg(RegHorizDisplayed, 8'($urandom_range(200, 255)));
          set_reg(RegVsyncPos, 8'($urandom_range(0, 127)));
          set_reg(RegVertDisplayed, 8'($urandom));
          runlen = 280;
        end
        default: begin
          for (int i = 0; i < NumRegs; i++) set_reg(4'(i), 8'($urandom));
          runlen = 90;
        end
      endcase
      for (int j = 0; j < runlen; j++) begin
        if ($urandom_range(0, 9) == 0) push_item(kind_t'($urandom_range(0, 2)), 8'($urandom));
        else push_item(KIND_TICK, 8'($urandom));
        if (j == 4 && phase % 3 == 1) hold_req = 1'b1;
      end
      phase++;
    end

    wait_drained();
    repeat (TailCycles) @(negedge clk);
    $display("covered %0d transactions: %0d line ticks, %0d drawn lines, %0d interrupts",
             sent, tick_count, draw_count, irq_count);
    $display("%0d register setups, %0d long output hold-offs, %0d mismatches",
             phase, holds, mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("PASS crtc_line_timing_irq");
    end else begin
      $display("FAIL crtc_line_timing_irq");
    end
    $finish;
  end

endmodule
